>>> src/sorted_priority_queue_defines.svh
// Assertion macros for the sorted priority queue RTL.
// Included by the modules that carry concurrent checks; uses clk_i and rst_ni.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/spq_pkg.sv
// Shared types for the sorted priority queue: mode and status codes,
// controller state and the command/status structs. No dependencies.
package spq_pkg;

  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } spq_mode_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_e;

  typedef enum logic {
    OUT_IDLE = 1'b0,
    OUT_HELD = 1'b1
  } spq_state_e;

  localparam int unsigned PrioW = 8;
  localparam int unsigned DataW = 32;
  localparam int unsigned OccW  = 5;

  // Controller to datapath.
  typedef struct packed {
    logic        push;
    logic        pop;
    logic        load;
    spq_status_e code;
  } spq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic empty;
  } spq_stat_t;

endpackage

>>> src/spq_ctrl.sv
// Controller of the sorted priority queue: output-register state machine and
// command decode. Depends on spq_pkg and sorted_priority_queue_defines.svh.
`include "sorted_priority_queue_defines.svh"

module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  spq_pkg::spq_stat_t stat_i,
  output spq_pkg::spq_cmd_t  cmd_o
);
  import spq_pkg::*;

  spq_state_e state_q, state_d;
  logic       accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= OUT_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: a new item fills the result register; otherwise a taken
  // result empties it.
  always_comb begin
    state_d = state_q;
    case (state_q)
      OUT_IDLE: begin
        if (accept) state_d = OUT_HELD;
      end
      OUT_HELD: begin
        if (accept) state_d = OUT_HELD;
        else if (out_ready_i) state_d = OUT_IDLE;
      end
      default: state_d = OUT_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      OUT_IDLE: begin
        in_ready_o = 1'b1;
      end
      OUT_HELD: begin
        in_ready_o  = out_ready_i;
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.load = accept;
    cmd_o.push = 1'b0;
    cmd_o.pop  = 1'b0;
    cmd_o.code = ST_DONE;
    if (spq_mode_e'(mode_i) == MODE_ENQ) begin
      if (stat_i.full) cmd_o.code = ST_FULL;
      else cmd_o.push = accept;
    end else begin
      if (stat_i.empty) cmd_o.code = ST_EMPTY;
      else cmd_o.pop = accept;
    end
  end

  `SPQ_ASSERT_NOW(a_push_pop_excl, 1'b1, !(cmd_o.push && cmd_o.pop), "push and pop together")
  `SPQ_ASSERT_NOW(a_held_no_load, out_valid_o && !out_ready_i, !cmd_o.load,
                  "result overwritten while stalled")
  `SPQ_ASSERT_NEXT(a_load_shows, cmd_o.load, out_valid_o, "loaded result not presented")

endmodule

>>> src/spq_dpath.sv
// Datapath of the sorted priority queue: a row of compare-and-shift cells,
// the entry count and the result register. Depends on spq_pkg and the defines.
`include "sorted_priority_queue_defines.svh"

module spq_dpath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  spq_pkg::spq_cmd_t          cmd_i,
  output spq_pkg::spq_stat_t         stat_o,
  input  logic [spq_pkg::PrioW-1:0]  prio_i,
  input  logic [spq_pkg::DataW-1:0]  data_i,
  output logic [1:0]                 res_status_o,
  output logic [spq_pkg::PrioW-1:0]  res_prio_o,
  output logic [spq_pkg::DataW-1:0]  res_data_o,
  output logic [spq_pkg::OccW-1:0]   res_occ_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]  count_q, count_d;
  logic [PrioW-1:0] prio_q [CAPACITY];
  logic [DataW-1:0] data_q [CAPACITY];
  // stay[k]: cell k holds a valid entry that the new item goes behind.
  logic [CAPACITY-1:0] stay;
  logic [CntW+OccW-1:0] occ_ext;

  assign stat_o.full  = (count_q == CntW'(CAPACITY));
  assign stat_o.empty = (count_q == '0);

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [PrioW-1:0] ins_prio, pop_prio, prio_d;
    logic [DataW-1:0] ins_data, pop_data, data_d;

    assign stay[k] = (CntW'(k) < count_q) && (prio_q[k] <= prio_i);

    if (k == 0) begin : g_first
      assign ins_prio  = prio_i;
      assign ins_data  = data_i;
    end else begin : g_rest
      assign ins_prio  = stay[k-1] ? prio_i : prio_q[k-1];
      assign ins_data  = stay[k-1] ? data_i : data_q[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign pop_prio = prio_q[k];
      assign pop_data = data_q[k];
    end else begin : g_mid
      assign pop_prio = prio_q[k+1];
      assign pop_data = data_q[k+1];
    end

    always_comb begin
      prio_d = prio_q[k];
      data_d = data_q[k];
      if (cmd_i.push && !stay[k]) begin
        prio_d = ins_prio;
        data_d = ins_data;
      end else if (cmd_i.pop) begin
        prio_d = pop_prio;
        data_d = pop_data;
      end
    end

    always_ff @(posedge clk_i) begin
      prio_q[k] <= prio_d;
      data_q[k] <= data_d;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.push) count_d = count_q + CntW'(1);
    else if (cmd_i.pop) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign occ_ext = {{OccW{1'b0}}, count_d};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_status_o <= cmd_i.code;
      res_prio_o   <= cmd_i.pop ? prio_q[0] : '0;
      res_data_o   <= cmd_i.pop ? data_q[0] : '0;
      res_occ_o    <= occ_ext[OccW-1:0];
    end
  end

  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(CAPACITY), "count above capacity")
  `SPQ_ASSERT_NEXT(a_push_count, cmd_i.push, count_q == $past(count_q) + CntW'(1),
                   "push did not grow count")
  `SPQ_ASSERT_NOW(a_head_sorted, count_q >= CntW'(2), prio_q[0] <= prio_q[1],
                  "head entries out of order")

endmodule

>>> src/sorted_priority_queue.sv
// Top level of the sorted priority queue: stream ports, controller and
// datapath. Depends on spq_pkg, spq_ctrl and spq_dpath.
//
// Usage: each item on the slave stream is one operation. tuser selects it:
// 0 enqueues the priority and payload in tdata, 1 dequeues the head entry.
// Entries are kept sorted, smallest priority first; equal priorities leave in
// arrival order. Every item gives exactly one result item on the master
// stream: tuser carries the status (done, full, empty) and tdata carries the
// dequeued priority and payload (zero unless a dequeue succeeded) and the
// occupancy after the operation.
// The result appears in the cycle after the item is accepted. Throughput is
// one item per cycle while the receiver takes each result, set by the row of
// compare-and-shift cells, which inserts or pops in parallel across all cells.
// A result waits in the output register while the receiver stalls; a new
// item is accepted in the same cycle the waiting result is taken.
// Reset empties the queue at once; no clearing pass is needed since only
// occupied cells ever reach the result.
module sorted_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // [7:0] priority_req, [39:8] payload
  input  logic        s_axis_tuser_i,  // [0] mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // [7:0] out_priority, [39:8] out_payload,
                                       // [44:40] occupancy, [47:45] zero
  output logic [1:0]  m_axis_tuser_o   // [1:0] status
);
  import spq_pkg::*;

  spq_cmd_t         cmd;
  spq_stat_t        stat;
  logic [PrioW-1:0] res_prio;
  logic [DataW-1:0] res_data;
  logic [OccW-1:0]  res_occ;

  // The controller owns the handshake and decodes each item into a command.
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .mode_i      (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds the sorted cells, the count and the result register.
  spq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .prio_i       (s_axis_tdata_i[7:0]),
    .data_i       (s_axis_tdata_i[39:8]),
    .res_status_o (m_axis_tuser_o),
    .res_prio_o   (res_prio),
    .res_data_o   (res_data),
    .res_occ_o    (res_occ)
  );

  assign m_axis_tdata_o = {3'b000, res_occ, res_data, res_prio};

endmodule
